/* src/rsb_pkg.sv */
// Shared types and constants for the base-10 radix sorter.
package rsb_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VAL_W         = 31;
  localparam int DIGITS        = 10;
  localparam int DIG_W         = 4;
  localparam int BCD_W         = DIGITS * DIG_W;
  localparam int ENT_W         = VAL_W + BCD_W;
  localparam int CONV_STEPS    = VAL_W;
  localparam int STEP_W        = 5;

  typedef enum logic [1:0] {
    ACT_COUNT,
    ACT_SCATTER,
    ACT_COPY
  } act_op_e;

  typedef struct packed {
    logic             rd_en;
    logic             act_vld;
    act_op_e          act_op;
    logic             conv_start;
    logic             conv_step;
    logic             store_wr;
    logic             clr_bins;
    logic             pfx_en;
    logic [DIG_W-1:0] pfx_idx;
    logic [DIG_W-1:0] digit;
    logic             out_load;
    logic             out_last;
    logic             clr_set;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pass_more;
  } sts_t;

endpackage

/* src/rsb_datapath.sv */
// Datapath: BCD converter, item and scatter memories, digit bins, max tracking, output register.
module rsb_datapath import rsb_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [VAL_W-1:0]                       value_i,
  input  cmd_t                                   cmd_i,
  input  logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] rd_addr_i,
  output logic [$clog2(MAX_ITEMS+1)-1:0]         cnt_o,
  output sts_t                                   sts_o,
  output logic [VAL_W-1:0]                       sorted_value_o,
  output logic                                   last_res_o
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [ENT_W-1:0] store_mem [MAX_ITEMS];
  logic [ENT_W-1:0] scat_mem  [MAX_ITEMS];
  logic [ENT_W-1:0] st_rd_q, sc_rd_q;
  logic [IDX_W-1:0] addr_q;

  logic [VAL_W-1:0] val_q, sh_bin_q;
  logic [BCD_W-1:0] sh_bcd_q, bcd_adj;

  logic [CNT_W-1:0] cnt_q;
  logic [VAL_W-1:0] max_q;
  logic [BCD_W-1:0] max_bcd_q;
  logic [DIG_W-1:0] top_dig;

  logic [CNT_W-1:0] bins_q [DIGITS];
  logic [DIG_W-1:0] key;
  logic [CNT_W-1:0] pos_full;
  logic [IDX_W-1:0] sc_pos;

  logic [VAL_W-1:0] out_val_q;
  logic             out_last_q;

  // double-dabble add-3 correction
  always_comb begin
    logic [DIG_W-1:0] dg;
    for (int j = 0; j < DIGITS; j++) begin
      dg = sh_bcd_q[j*DIG_W +: DIG_W];
      bcd_adj[j*DIG_W +: DIG_W] = (dg >= 4'd5) ? dg + 4'd3 : dg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv_start) begin
      val_q    <= value_i;
      sh_bin_q <= value_i;
      sh_bcd_q <= '0;
    end else if (cmd_i.conv_step) begin
      {sh_bcd_q, sh_bin_q} <= {bcd_adj[BCD_W-2:0], sh_bin_q, 1'b0};
    end
  end

  assign key      = st_rd_q[cmd_i.digit*DIG_W +: DIG_W];
  assign pos_full = bins_q[key] - CNT_W'(1);
  assign sc_pos   = pos_full[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      store_mem[cnt_q[IDX_W-1:0]] <= {val_q, sh_bcd_q};
    end else if (cmd_i.act_vld && cmd_i.act_op == ACT_COPY) begin
      store_mem[addr_q] <= sc_rd_q;
    end
    if (cmd_i.act_vld && cmd_i.act_op == ACT_SCATTER) begin
      scat_mem[sc_pos] <= st_rd_q;
    end
    if (cmd_i.rd_en) begin
      st_rd_q <= store_mem[rd_addr_i];
      sc_rd_q <= scat_mem[rd_addr_i];
      addr_q  <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DIGITS; j++) bins_q[j] <= '0;
    end else if (cmd_i.clr_bins) begin
      for (int j = 0; j < DIGITS; j++) bins_q[j] <= '0;
    end else if (cmd_i.pfx_en) begin
      bins_q[cmd_i.pfx_idx] <= bins_q[cmd_i.pfx_idx] + bins_q[cmd_i.pfx_idx - 4'd1];
    end else if (cmd_i.act_vld) begin
      case (cmd_i.act_op)
        ACT_COUNT:   bins_q[key] <= bins_q[key] + CNT_W'(1);
        ACT_SCATTER: bins_q[key] <= pos_full;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      max_q     <= '0;
      max_bcd_q <= '0;
    end else if (cmd_i.clr_set) begin
      cnt_q     <= '0;
      max_q     <= '0;
      max_bcd_q <= '0;
    end else if (cmd_i.store_wr) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (val_q > max_q) begin
        max_q     <= val_q;
        max_bcd_q <= sh_bcd_q;
      end
    end
  end

  always_comb begin
    top_dig = '0;
    for (int j = 0; j < DIGITS; j++) begin
      if (max_bcd_q[j*DIG_W +: DIG_W] != '0) top_dig = DIG_W'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_val_q  <= st_rd_q[ENT_W-1:BCD_W];
      out_last_q <= cmd_i.out_last;
    end
  end

  assign cnt_o          = cnt_q;
  assign sts_o.full     = (cnt_q == CNT_W'(MAX_ITEMS));
  assign sts_o.pass_more = (max_q != '0) && (cmd_i.digit <= top_dig);
  assign sorted_value_o = out_val_q;
  assign last_res_o     = out_last_q;

endmodule

/* src/rsb_ctrl.sv */
// Controller: sequences load, conversion, count/prefix/scatter/copy passes and output.
module rsb_ctrl import rsb_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   last_i,
  output logic                                   in_stall_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]         cnt_i,
  input  sts_t                                   sts_i,
  output cmd_t                                   cmd_o,
  output logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] rd_addr_o
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CONV  = 4'd1;
  localparam logic [3:0] S_STORE = 4'd2;
  localparam logic [3:0] S_PINIT = 4'd3;
  localparam logic [3:0] S_CNT   = 4'd4;
  localparam logic [3:0] S_PFX   = 4'd5;
  localparam logic [3:0] S_SCT   = 4'd6;
  localparam logic [3:0] S_CPY   = 4'd7;
  localparam logic [3:0] S_ORD   = 4'd8;
  localparam logic [3:0] S_OLD   = 4'd9;
  localparam logic [3:0] S_OWAIT = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIG_W-1:0]  pass_q, pass_d;
  logic              last_q, last_d;
  logic              act_vld_q, act_vld_d;
  act_op_e           act_op_q, act_op_d;
  logic              walk_end;
  logic [CNT_W-1:0]  rev_idx, last_idx;

  assign walk_end = (idx_q == cnt_i);
  assign last_idx = cnt_i - CNT_W'(1);
  assign rev_idx  = last_idx - idx_q;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    step_d    = step_q;
    pass_d    = pass_q;
    last_d    = last_q;
    act_vld_d = 1'b0;
    act_op_d  = act_op_q;
    cmd_o     = '0;
    cmd_o.act_vld = act_vld_q;
    cmd_o.act_op  = act_op_q;
    cmd_o.digit   = pass_q;
    cmd_o.pfx_idx = step_q[DIG_W-1:0];
    rd_addr_o     = idx_q[IDX_W-1:0];
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (!sts_i.full) begin
            cmd_o.conv_start = 1'b1;
            last_d  = last_i;
            step_d  = '0;
            state_d = S_CONV;
          end else if (last_i) begin
            pass_d  = '0;
            state_d = S_PINIT;
          end
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(CONV_STEPS - 1)) state_d = S_STORE;
      end
      S_STORE: begin
        cmd_o.store_wr = 1'b1;
        if (last_q) begin
          pass_d  = '0;
          state_d = S_PINIT;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_PINIT: begin
        idx_d = '0;
        if (sts_i.pass_more) begin
          cmd_o.clr_bins = 1'b1;
          state_d = S_CNT;
        end else begin
          state_d = S_ORD;
        end
      end
      S_CNT: begin
        if (!walk_end) begin
          cmd_o.rd_en = 1'b1;
          act_vld_d   = 1'b1;
          act_op_d    = ACT_COUNT;
          idx_d       = idx_q + CNT_W'(1);
        end else begin
          step_d  = STEP_W'(1);
          state_d = S_PFX;
        end
      end
      S_PFX: begin
        cmd_o.pfx_en = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIGITS - 1)) begin
          idx_d   = '0;
          state_d = S_SCT;
        end
      end
      S_SCT: begin
        rd_addr_o = rev_idx[IDX_W-1:0];
        if (!walk_end) begin
          cmd_o.rd_en = 1'b1;
          act_vld_d   = 1'b1;
          act_op_d    = ACT_SCATTER;
          idx_d       = idx_q + CNT_W'(1);
        end else begin
          idx_d   = '0;
          state_d = S_CPY;
        end
      end
      S_CPY: begin
        if (!walk_end) begin
          cmd_o.rd_en = 1'b1;
          act_vld_d   = 1'b1;
          act_op_d    = ACT_COPY;
          idx_d       = idx_q + CNT_W'(1);
        end else begin
          pass_d  = pass_q + DIG_W'(1);
          state_d = S_PINIT;
        end
      end
      S_ORD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_OLD;
      end
      S_OLD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = (idx_q == last_idx);
        state_d = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall_i) begin
          if (idx_q == last_idx) begin
            cmd_o.clr_set = 1'b1;
            idx_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      idx_q     <= '0;
      step_q    <= '0;
      pass_q    <= '0;
      last_q    <= 1'b0;
      act_vld_q <= 1'b0;
      act_op_q  <= ACT_COUNT;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      step_q    <= step_d;
      pass_q    <= pass_d;
      last_q    <= last_d;
      act_vld_q <= act_vld_d;
      act_op_q  <= act_op_d;
    end
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = (state_q == S_OWAIT);

`ifndef ASSERT_OFF
  a_act_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_vld_q |-> $past(cmd_o.rd_en))
    else $error("datapath action without a preceding read");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OWAIT && out_stall_i) |=> (state_q == S_OWAIT))
    else $error("result dropped while stalled");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= cnt_i)
    else $error("walk index beyond item count");

  a_pass_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CNT || state_q == S_SCT || state_q == S_CPY) |-> (pass_q <= 4'd9))
    else $error("pass digit out of range");
`endif

endmodule

/* src/radix_sort_base10.sv */
// Top level of the base-10 LSD radix sorter.
// Usage:
//   Input channel (in_valid_i / in_stall_o, value_i, last_i): one value per
//   transaction; last_i marks the final value of a set. Up to MAX_ITEMS values
//   are kept; values beyond that are dropped, but a dropped last still sorts.
//   Each stored value is accepted, converted to BCD by double dabble and stored,
//   the input stalled meanwhile; a dropped value is only accepted.
//   Sorting: one pass per decimal digit of the set maximum (0 to 10 passes),
//   each pass a count walk over the N stored values, 9 prefix steps, a scatter
//   walk and a copy walk between the item and scatter memories.
//   Output channel (out_valid_o / out_stall_i, sorted_value_o, last_res_o):
//   values in ascending order, last_res_o on the final one. Each result
//   is read, registered and offered. A stall holds the current result and its
//   payload until taken. After the final result the block accepts a new set.
//   Input is stalled from the last value of a set until its last result.
//   Reset leaves the block empty and ready; memories need no clearing.
module radix_sort_base10 import rsb_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [VAL_W-1:0] value_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] sorted_value_o,
  output logic             last_res_o
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] rd_addr;

  rsb_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cnt_i      (cnt),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  rsb_datapath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .cnt_o         (cnt),
    .sts_o         (sts),
    .sorted_value_o(sorted_value_o),
    .last_res_o    (last_res_o)
  );

endmodule
